[sv/midpoint_circle_half_outline_defines.svh]
// ----------------------------------------------------------------------------
// Midpoint circle half outline: assertion macros
// Shared concurrent assertion macros for the circle outline generator.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_HALF_OUTLINE_DEFINES_SVH
`define MIDPOINT_CIRCLE_HALF_OUTLINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion, disabled while reset is held.
`define MCHO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MCHO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define MCHO_ASSERT(label, prop, msg)
`define MCHO_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[sv/mcho_pkg.sv]
// ----------------------------------------------------------------------------
// Midpoint circle half outline: package
// Widths, limits, opcodes and controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none

package mcho_pkg;

  localparam int CENTER_W    = 11;
  localparam int RADIUS_W    = 7;
  localparam int COLOR_W     = 16;
  localparam int OPCODE_W    = 2;
  localparam int COORD_OUT_W = 13;

  localparam int MAX_RADIUS_DEF = 88;
  localparam int COORD_BITS_DEF = 11;

  // Step budget of one command.
  localparam int MAX_STEPS  = 64;
  localparam int STEP_CNT_W = $clog2(MAX_STEPS);

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOWER = 2'd0,
    OP_UPPER = 2'd1,
    OP_ARC   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

[sv/mcho_cmd_if.sv]
// ----------------------------------------------------------------------------
// Midpoint circle half outline: command channel
// Valid/ready channel that carries one draw command per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcho_cmd_if;

  logic                               valid;
  logic                               ready;
  logic [mcho_pkg::OPCODE_W-1:0]      opcode;
  logic [mcho_pkg::CENTER_W-1:0]      center_x;
  logic [mcho_pkg::CENTER_W-1:0]      center_y;
  logic [mcho_pkg::RADIUS_W-1:0]      radius;
  logic [mcho_pkg::COLOR_W-1:0]       pen_color;

  modport source (
    output valid, opcode, center_x, center_y, radius, pen_color,
    input  ready
  );

  modport sink (
    input  valid, opcode, center_x, center_y, radius, pen_color,
    output ready
  );

endinterface

`default_nettype wire

[sv/mcho_res_if.sv]
// ----------------------------------------------------------------------------
// Midpoint circle half outline: result channel
// Valid/ready channel that carries one mirrored pixel group per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcho_res_if;

  logic                                    valid;
  logic                                    ready;
  logic signed [mcho_pkg::COORD_OUT_W-1:0] near_x_plus;
  logic signed [mcho_pkg::COORD_OUT_W-1:0] near_x_minus;
  logic signed [mcho_pkg::COORD_OUT_W-1:0] near_row;
  logic signed [mcho_pkg::COORD_OUT_W-1:0] far_x_plus;
  logic signed [mcho_pkg::COORD_OUT_W-1:0] far_x_minus;
  logic signed [mcho_pkg::COORD_OUT_W-1:0] far_row;
  logic                                    far_valid;
  logic [mcho_pkg::COLOR_W-1:0]            out_color;
  logic                                    last_step;

  modport source (
    output valid, near_x_plus, near_x_minus, near_row, far_x_plus, far_x_minus,
           far_row, far_valid, out_color, last_step,
    input  ready
  );

  modport sink (
    input  valid, near_x_plus, near_x_minus, near_row, far_x_plus, far_x_minus,
           far_row, far_valid, out_color, last_step,
    output ready
  );

endinterface

`default_nettype wire

[sv/midpoint_circle_half_outline.sv]
// ----------------------------------------------------------------------------
// Midpoint circle half outline generator
// Expands one draw command into a burst of mirrored outline pixel groups.
// ----------------------------------------------------------------------------
// Flow: accepting a drawable command moves the controller from idle to run;
//   in run, each step loads one result into the result register while that
//   register is empty or the sink keeps ready high.
// Throughput: a command yields 1 to 64 results from the single recurrence
//   register set, which advances one step per cycle while the result register
//   is empty or drained; a command with the unused opcode is taken and dropped.
// Reset: asynchronous, active low; clears the controller to idle with no
//   pending result. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_half_outline #(
  parameter int MAX_RADIUS = mcho_pkg::MAX_RADIUS_DEF,
  parameter int COORD_BITS = mcho_pkg::COORD_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mcho_cmd_if.sink   cmd_i,
  mcho_res_if.source res_o
);

  // The controller owns the handshakes and the run/idle state. It issues a
  // load when a drawable command is accepted and, in the run state, a step
  // whenever the result register is empty or is being drained this cycle. The
  // datapath reports whether its current step is the final one of the command,
  // either because the octant walk ends or because the 64-item budget is used.
  mcho_pkg::ctrl_cmd_t  dp_cmd;
  mcho_pkg::dp_status_t dp_status;

  mcho_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_i.valid),
    .cmd_opcode_i (cmd_i.opcode),
    .cmd_ready_o  (cmd_i.ready),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .dp_cmd_o     (dp_cmd),
    .dp_status_i  (dp_status)
  );

  // The datapath holds the captured command, the x/y/decision recurrence and
  // the result register. Because the result register is separate from the
  // recurrence, a new command can be accepted while the final item of the
  // previous command still waits for the sink.
  mcho_dpath #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dp_cmd_i       (dp_cmd),
    .dp_status_o    (dp_status),
    .opcode_i       (cmd_i.opcode),
    .center_x_i     (cmd_i.center_x),
    .center_y_i     (cmd_i.center_y),
    .radius_i       (cmd_i.radius),
    .pen_color_i    (cmd_i.pen_color),
    .near_x_plus_o  (res_o.near_x_plus),
    .near_x_minus_o (res_o.near_x_minus),
    .near_row_o     (res_o.near_row),
    .far_x_plus_o   (res_o.far_x_plus),
    .far_x_minus_o  (res_o.far_x_minus),
    .far_row_o      (res_o.far_row),
    .far_valid_o    (res_o.far_valid),
    .out_color_o    (res_o.out_color),
    .last_step_o    (res_o.last_step)
  );

endmodule

`default_nettype wire

[sv/mcho_ctrl.sv]
// ----------------------------------------------------------------------------
// Midpoint circle half outline: controller
// Command acceptance, step sequencing and output valid tracking.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midpoint_circle_half_outline_defines.svh"

module mcho_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cmd_valid_i,
  input  wire logic [mcho_pkg::OPCODE_W-1:0]   cmd_opcode_i,
  output logic                                 cmd_ready_o,
  output logic                                 res_valid_o,
  input  wire logic                            res_ready_i,
  output mcho_pkg::ctrl_cmd_t                  dp_cmd_o,
  input  wire mcho_pkg::dp_status_t            dp_status_i
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   slot_free;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign slot_free   = !out_valid_q || res_ready_i;

  // An unused opcode is accepted and dropped without a load.
  assign dp_cmd_o.load = accept &&
                         (mcho_pkg::opcode_e'(cmd_opcode_i) != mcho_pkg::OP_NONE);
  assign dp_cmd_o.step = (state_q == ST_RUN) && slot_free;

  assign res_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (dp_cmd_o.step) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (dp_cmd_o.load) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (dp_cmd_o.step && dp_status_i.last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `MCHO_ASSERT(a_load_starts_run, dp_cmd_o.load |=> (state_q == ST_RUN && !cmd_ready_o),
               "load did not start a run")
  `MCHO_ASSERT(a_last_ends_run,
               (dp_cmd_o.step && dp_status_i.last) |=> (state_q == ST_IDLE && res_valid_o),
               "final step did not return to idle with a pending result")
  `MCHO_ASSERT(a_step_shows_result, dp_cmd_o.step |=> res_valid_o,
               "step did not present a result")
  `MCHO_ASSERT_ALWAYS(a_no_step_in_reset, !rst_ni |-> !dp_cmd_o.step,
               "step issued during reset")

endmodule

`default_nettype wire

[sv/mcho_dpath.sv]
// ----------------------------------------------------------------------------
// Midpoint circle half outline: datapath
// Midpoint recurrence registers, pixel mirroring and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midpoint_circle_half_outline_defines.svh"

module mcho_dpath #(
  parameter int MAX_RADIUS = mcho_pkg::MAX_RADIUS_DEF,
  parameter int COORD_BITS = mcho_pkg::COORD_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire mcho_pkg::ctrl_cmd_t                   dp_cmd_i,
  output mcho_pkg::dp_status_t                       dp_status_o,
  input  wire logic [mcho_pkg::OPCODE_W-1:0]         opcode_i,
  input  wire logic [mcho_pkg::CENTER_W-1:0]         center_x_i,
  input  wire logic [mcho_pkg::CENTER_W-1:0]         center_y_i,
  input  wire logic [mcho_pkg::RADIUS_W-1:0]         radius_i,
  input  wire logic [mcho_pkg::COLOR_W-1:0]          pen_color_i,
  output logic signed [mcho_pkg::COORD_OUT_W-1:0]    near_x_plus_o,
  output logic signed [mcho_pkg::COORD_OUT_W-1:0]    near_x_minus_o,
  output logic signed [mcho_pkg::COORD_OUT_W-1:0]    near_row_o,
  output logic signed [mcho_pkg::COORD_OUT_W-1:0]    far_x_plus_o,
  output logic signed [mcho_pkg::COORD_OUT_W-1:0]    far_x_minus_o,
  output logic signed [mcho_pkg::COORD_OUT_W-1:0]    far_row_o,
  output logic                                       far_valid_o,
  output logic [mcho_pkg::COLOR_W-1:0]               out_color_o,
  output logic                                       last_step_o
);

  localparam int CW = mcho_pkg::CENTER_W;
  localparam int OW = mcho_pkg::COORD_OUT_W;
  localparam int SW = mcho_pkg::STEP_CNT_W;
  localparam int MASK_BITS = (COORD_BITS < CW) ? COORD_BITS : CW;
  localparam logic [CW-1:0] CENTER_MASK = CW'((64'd1 << MASK_BITS) - 64'd1);
  localparam logic [mcho_pkg::RADIUS_W-1:0] RADIUS_MAX = mcho_pkg::RADIUS_W'(MAX_RADIUS);
  localparam logic [SW-1:0] LAST_CNT = SW'(mcho_pkg::MAX_STEPS - 1);

  // Walk state: x counts up from zero, y down from the radius (reaches -1 at
  // most), d is the midpoint decision value.
  mcho_pkg::opcode_e    mode_q;
  logic [CW-1:0]        cx_q;
  logic [CW-1:0]        cy_q;
  logic [mcho_pkg::COLOR_W-1:0] color_q;
  logic [6:0]           x_q;
  logic signed [8:0]    y_q;
  logic signed [11:0]   d_q;
  logic [SW-1:0]        cnt_q;

  logic [mcho_pkg::RADIUS_W-1:0] r_sat;
  logic signed [11:0]   x12;
  logic signed [11:0]   y12;
  logic signed [11:0]   d_next;
  logic signed [8:0]    y_next;
  logic [6:0]           x_next;
  logic signed [9:0]    xn10;
  logic signed [9:0]    yn10;
  logic                 cont_next;
  logic signed [OW-1:0] cx13;
  logic signed [OW-1:0] cy13;
  logic signed [OW-1:0] x13;
  logic signed [OW-1:0] y13;
  logic                 is_upper;
  logic                 is_arc;

  assign r_sat = (radius_i > RADIUS_MAX) ? RADIUS_MAX : radius_i;

  // Recurrence update for the step being emitted.
  assign x12 = $signed({5'b0, x_q});
  assign y12 = $signed({{3{y_q[8]}}, y_q});
  always_comb begin
    if (d_q[11]) begin
      d_next = d_q + (x12 <<< 2) + 12'sd6;
      y_next = y_q;
    end else begin
      d_next = d_q + ((x12 - y12) <<< 2) + 12'sd10;
      y_next = y_q - 9'sd1;
    end
  end
  assign x_next = x_q + 7'd1;

  // Loop test on the advanced values decides whether this step is the final one.
  assign xn10 = $signed({3'b000, x_next});
  assign yn10 = $signed({y_next[8], y_next});
  assign is_upper = (mode_q == mcho_pkg::OP_UPPER);
  assign is_arc   = (mode_q == mcho_pkg::OP_ARC);
  assign cont_next = is_arc ? (xn10 <= (yn10 >>> 2)) : (xn10 <= yn10);
  assign dp_status_o.last = !cont_next || (cnt_q == LAST_CNT);

  // Mirrored coordinates in 13-bit two's complement.
  assign cx13 = $signed({2'b00, cx_q});
  assign cy13 = $signed({2'b00, cy_q});
  assign x13  = $signed({6'b0, x_q});
  assign y13  = $signed({{4{y_q[8]}}, y_q});

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      mode_q  <= mcho_pkg::opcode_e'(opcode_i);
      cx_q    <= center_x_i & CENTER_MASK;
      cy_q    <= center_y_i & CENTER_MASK;
      color_q <= pen_color_i;
      x_q     <= 7'd0;
      y_q     <= $signed({2'b00, r_sat});
      d_q     <= 12'sd3 - $signed({4'b0, r_sat, 1'b0});
      cnt_q   <= '0;
    end else if (dp_cmd_i.step) begin
      x_q   <= x_next;
      y_q   <= y_next;
      d_q   <= d_next;
      cnt_q <= cnt_q + SW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.step) begin
      near_x_plus_o  <= cx13 + x13;
      near_x_minus_o <= cx13 - x13;
      near_row_o     <= is_upper ? (cy13 - y13) : (cy13 + y13);
      if (is_arc) begin
        far_x_plus_o  <= '0;
        far_x_minus_o <= '0;
        far_row_o     <= '0;
        far_valid_o   <= 1'b0;
      end else begin
        far_x_plus_o  <= cx13 + y13;
        far_x_minus_o <= cx13 - y13;
        far_row_o     <= is_upper ? (cy13 - x13) : (cy13 + x13);
        far_valid_o   <= 1'b1;
      end
      out_color_o <= color_q;
      last_step_o <= dp_status_o.last;
    end
  end

  `MCHO_ASSERT(a_step_inside_octant, dp_cmd_i.step |-> ($signed({2'b00, x_q}) <= y_q),
               "step emitted outside the octant")
  `MCHO_ASSERT(a_no_load_and_step, !(dp_cmd_i.load && dp_cmd_i.step),
               "load and step in the same cycle")

endmodule

`default_nettype wire
